// ===== sv/krr_pkg.sv =====
// Shared types and constants for the k-th remaining removal block.
// Used by krr_ctrl, krr_dp and the kth_remaining_removal top level.
package krr_pkg;

  localparam int CAPACITY    = 4096;
  localparam int VALUE_WIDTH = 64;

  // Fixed field widths of the ports
  localparam int VALUE_OUT_W = 64;
  localparam int RANK_W      = 13;
  localparam int POSITION_W  = 12;
  localparam int STATUS_W    = 2;

  // Count tree geometry: leaf count is the next power of two, node 1 is the root
  localparam int LEVELS     = $clog2(CAPACITY);
  localparam int LEAF_BASE  = 1 << LEVELS;
  localparam int TREE_DEPTH = 2 * LEAF_BASE;
  localparam int NODE_W     = LEVELS + 1;
  localparam int POS_W      = LEVELS;
  localparam int CNT_W      = LEVELS + 1;
  localparam int LVL_W      = $clog2(LEVELS + 2);
  localparam int CMP_W      = (RANK_W > CNT_W) ? RANK_W : CNT_W;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_RANK = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  // Controller -> datapath
  typedef struct packed {
    logic    capture;
    logic    load_begin;
    logic    desc_begin;
    logic    desc_rd;
    logic    desc_step;
    logic    upd_step;
    logic    finish;
    status_e status;
  } ctl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_remove;
    logic full;
    logic bad_rank;
    logic desc_last;
    logic upd_done;
  } dp_sts_t;

endpackage

// ===== sv/krr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module krr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/krr_ctrl.sv =====
// Sequencer for load, tree descent and count update of the removal block.
// Depends on krr_pkg.
module krr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output krr_pkg::ctl_cmd_t cmd_o,
  input  krr_pkg::dp_sts_t  sts_i
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_CHECK    = 5'b00010,
    S_DESC_RD  = 5'b00100,
    S_DESC_CMP = 5'b01000,
    S_UPD      = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status = krr_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts_i.is_remove) begin
          if (sts_i.full) begin
            cmd_o.finish = 1'b1;
            cmd_o.status = krr_pkg::ST_FULL;
            state_d = S_IDLE;
          end else begin
            cmd_o.load_begin = 1'b1;
            state_d = S_UPD;
          end
        end else if (sts_i.bad_rank) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = krr_pkg::ST_BAD_RANK;
          state_d = S_IDLE;
        end else begin
          cmd_o.desc_begin = 1'b1;
          state_d = S_DESC_RD;
        end
      end
      S_DESC_RD: begin
        cmd_o.desc_rd = 1'b1;
        state_d = S_DESC_CMP;
      end
      S_DESC_CMP: begin
        cmd_o.desc_step = 1'b1;
        state_d = sts_i.desc_last ? S_UPD : S_DESC_RD;
      end
      S_UPD: begin
        cmd_o.upd_step = 1'b1;
        if (sts_i.upd_done) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  // a compare step always follows its read
  a_cmp_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DESC_CMP |-> $past(state_q) == S_DESC_RD)
    else $error("descent compare without preceding read");

  // the tree walk is only entered from check or descent
  a_upd_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == S_UPD) |-> $past(state_q) == S_CHECK || $past(state_q) == S_DESC_CMP)
    else $error("update entered from wrong state");

endmodule

// ===== sv/krr_dp.sv =====
// Datapath: value store, count tree RAM, descent and path-update registers.
// Depends on krr_pkg and krr_ram.
module krr_dp (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  krr_pkg::ctl_cmd_t                           cmd_i,
  output krr_pkg::dp_sts_t                            sts_o,
  input  logic                                        kind_i,
  input  logic signed [krr_pkg::VALUE_OUT_W-1:0]      value_i,
  input  logic        [krr_pkg::RANK_W-1:0]           rank_i,
  output logic                                        done_o,
  output logic signed [krr_pkg::VALUE_OUT_W-1:0]      removed_value_o,
  output logic        [krr_pkg::POSITION_W-1:0]       removed_position_o,
  output logic        [krr_pkg::STATUS_W-1:0]         status_o
);

  localparam int VW = krr_pkg::VALUE_WIDTH;
  localparam int NW = krr_pkg::NODE_W;
  localparam int PW = krr_pkg::POS_W;
  localparam int CW = krr_pkg::CNT_W;
  localparam int LW = krr_pkg::LVL_W;

  // captured item
  logic                         kind_q;
  logic [VW-1:0]                value_q;
  logic [krr_pkg::RANK_W-1:0]   rank_q;

  // persistent counters
  logic [CW-1:0] loaded_q, loaded_d;
  logic [CW-1:0] remaining_q, remaining_d;

  // walk registers
  logic [NW-1:0] node_q;
  logic [PW-1:0] pos_q;
  logic [PW-1:0] bit_q;
  logic [CW-1:0] k_q;
  logic [LW-1:0] lvl_q;

  // write stage of the path update
  logic          wr_pend_q;
  logic [NW-1:0] wr_node_q;
  logic          fresh_q;

  // result word
  logic                                    res_valid_q;
  logic signed [krr_pkg::VALUE_OUT_W-1:0]  res_value_q;
  logic        [krr_pkg::POSITION_W-1:0]   res_pos_q;
  krr_pkg::status_e                        res_status_q;

  // RAM hookup
  logic          tree_re;
  logic [NW-1:0] tree_raddr;
  logic [CW-1:0] tree_rdata;
  logic [CW-1:0] tree_wdata;
  logic [VW-1:0] val_rdata;
  logic signed [VW-1:0] val_rdata_s;

  logic          untouched;
  logic [CW-1:0] left_cnt;
  logic          go_left;
  logic          fresh_now;
  logic          remove_ok;

  assign tree_re    = cmd_i.desc_rd | cmd_i.upd_step;
  assign tree_raddr = cmd_i.desc_rd ? {node_q[NW-2:0], 1'b0} : node_q;
  assign tree_wdata = fresh_q ? CW'(1) :
                      (kind_q == krr_pkg::KIND_REMOVE) ? (tree_rdata - CW'(1))
                                                       : (tree_rdata + CW'(1));

  krr_ram #(
    .WIDTH (CW),
    .DEPTH (krr_pkg::TREE_DEPTH)
  ) u_tree_ram (
    .clk_i   (clk_i),
    .we_i    (wr_pend_q),
    .waddr_i (wr_node_q),
    .wdata_i (tree_wdata),
    .re_i    (tree_re),
    .raddr_i (tree_raddr),
    .rdata_o (tree_rdata)
  );

  krr_ram #(
    .WIDTH (VW),
    .DEPTH (krr_pkg::CAPACITY)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_begin),
    .waddr_i (PW'(loaded_q)),
    .wdata_i (value_q),
    .re_i    (cmd_i.upd_step),
    .raddr_i (pos_q),
    .rdata_o (val_rdata)
  );

  assign val_rdata_s = val_rdata;

  // Tree nodes whose first leaf lies at or past the load count were never
  // written; they read as zero. Left child's first leaf is pos_q.
  assign untouched = ({1'b0, pos_q} >= (PW+1)'(loaded_q));
  assign left_cnt  = untouched ? '0 : tree_rdata;
  assign go_left   = (left_cnt >= k_q);

  // on load, a node is first touched when the loaded position is its first leaf
  assign fresh_now = (kind_q == krr_pkg::KIND_LOAD) &&
                     ((pos_q & ~({PW{1'b1}} << lvl_q)) == '0);

  assign remove_ok = (kind_q == krr_pkg::KIND_REMOVE) && (cmd_i.status == krr_pkg::ST_OK);

  always_comb begin
    sts_o.is_remove = (kind_q == krr_pkg::KIND_REMOVE);
    sts_o.full      = (loaded_q == CW'(krr_pkg::CAPACITY));
    sts_o.bad_rank  = (rank_q == '0) ||
                      (krr_pkg::CMP_W'(rank_q) > krr_pkg::CMP_W'(remaining_q));
    sts_o.desc_last = (lvl_q == LW'(krr_pkg::LEVELS - 1));
    sts_o.upd_done  = (node_q == '0);
  end

  always_comb begin
    loaded_d    = loaded_q;
    remaining_d = remaining_q;
    if (cmd_i.finish && cmd_i.status == krr_pkg::ST_OK) begin
      if (kind_q == krr_pkg::KIND_LOAD) begin
        loaded_d    = loaded_q + CW'(1);
        remaining_d = remaining_q + CW'(1);
      end else begin
        remaining_d = remaining_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= '0;
      remaining_q <= '0;
      wr_pend_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      loaded_q    <= loaded_d;
      remaining_q <= remaining_d;
      wr_pend_q   <= cmd_i.upd_step && (node_q != '0);
      res_valid_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= kind_i;
      value_q <= VW'(value_i);
      rank_q  <= rank_i;
    end
    if (cmd_i.load_begin) begin
      node_q <= NW'(krr_pkg::LEAF_BASE) + NW'(loaded_q);
      pos_q  <= PW'(loaded_q);
      lvl_q  <= '0;
    end
    if (cmd_i.desc_begin) begin
      node_q <= NW'(1);
      pos_q  <= '0;
      bit_q  <= PW'(1) << (PW - 1);
      k_q    <= CW'(rank_q);
      lvl_q  <= '0;
    end
    if (cmd_i.desc_step) begin
      node_q <= {node_q[NW-2:0], ~go_left};
      if (!go_left) begin
        k_q   <= k_q - left_cnt;
        pos_q <= pos_q | bit_q;
      end
      bit_q <= bit_q >> 1;
      lvl_q <= sts_o.desc_last ? '0 : lvl_q + LW'(1);
    end
    if (cmd_i.upd_step && node_q != '0) begin
      node_q    <= node_q >> 1;
      lvl_q     <= lvl_q + LW'(1);
      wr_node_q <= node_q;
      fresh_q   <= fresh_now;
    end
    if (cmd_i.finish) begin
      res_status_q <= cmd_i.status;
      res_value_q  <= remove_ok ? krr_pkg::VALUE_OUT_W'(val_rdata_s) : '0;
      res_pos_q    <= remove_ok ? krr_pkg::POSITION_W'(pos_q) : '0;
    end
  end

  assign done_o             = res_valid_q;
  assign removed_value_o    = res_value_q;
  assign removed_position_o = res_pos_q;
  assign status_o           = res_status_q;

  a_remaining_le_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    remaining_q <= loaded_q)
    else $error("remaining count exceeds loaded count");

  a_no_root_parent_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> wr_node_q != '0)
    else $error("count write to node zero");

  a_err_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_status_q != krr_pkg::ST_OK |-> res_value_q == '0 && res_pos_q == '0)
    else $error("error word carries payload");

endmodule

// ===== sv/kth_remaining_removal.sv =====
// Top level of the k-th remaining removal block (order-statistic count tree).
// Depends on krr_pkg, krr_ctrl, krr_dp (and krr_ram through krr_dp).
//
// Usage: drive kind_i/value_i/rank_i with start_i high; the word is taken at a
// clock edge where start_i is high and busy_o is low. A load (kind 0) stores
// value_i at the next position and marks it present; a remove (kind 1) finds
// the rank_i-th still-present position, returns its value and position and
// clears it. Each word gives exactly one result: done_o is high for one cycle
// with removed_value_o, removed_position_o and status_o valid in that cycle.
// A load walks from its leaf back to the root, one node per cycle; a remove
// first descends the tree, a registered count-RAM read and then a compare per
// tree level, and then walks back to the root the same way. An error word
// ends in the check state. busy_o drops in the cycle done_o rises, so the
// next word may be accepted then. The receiver cannot stall; a result is lost
// if not sampled. Reset clears the load and remaining counts and needs no
// clearing pass: tree nodes beyond the load count read as zero.
module kth_remaining_removal (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  output logic                                    busy_o,
  input  logic                                    kind_i,
  input  logic signed [krr_pkg::VALUE_OUT_W-1:0]  value_i,
  input  logic        [krr_pkg::RANK_W-1:0]       rank_i,
  output logic                                    done_o,
  output logic signed [krr_pkg::VALUE_OUT_W-1:0]  removed_value_o,
  output logic        [krr_pkg::POSITION_W-1:0]   removed_position_o,
  output logic        [krr_pkg::STATUS_W-1:0]     status_o
);

  krr_pkg::ctl_cmd_t cmd;
  krr_pkg::dp_sts_t  sts;

  krr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  krr_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .kind_i             (kind_i),
    .value_i            (value_i),
    .rank_i             (rank_i),
    .done_o             (done_o),
    .removed_value_o    (removed_value_o),
    .removed_position_o (removed_position_o),
    .status_o           (status_o)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for kth_remaining_removal: a random mix of loads, removes
// at random ranks and bad ranks, checking every result word against a shadow list.
// Depends on krr_pkg and the kth_remaining_removal RTL.
module tb_top;
  import krr_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 60;
  localparam int RANDOM_WORDS = 780;

  typedef struct {
    kind_e              kind;
    logic [63:0]        value;
    logic [RANK_W-1:0]  rank;
  } word_t;

  typedef struct {
    logic signed [63:0]       value;
    logic [POSITION_W-1:0]    position;
    logic [STATUS_W-1:0]      status;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic kind_i = 1'b0;
  logic signed [VALUE_OUT_W-1:0] value_i = '0;
  logic [RANK_W-1:0] rank_i = '0;
  logic busy_o;
  logic done_o;
  logic signed [VALUE_OUT_W-1:0] removed_value_o;
  logic [POSITION_W-1:0] removed_position_o;
  logic [STATUS_W-1:0] status_o;

  word_t    pending_words[$];
  outcome_t outcome_q[$];

  // shadow of the block: positions still present, in load order
  int                 present_pos[$];
  logic signed [63:0] shadow_val[CAPACITY];
  int                 shadow_loaded = 0;

  // counts used while building the stimulus
  int gen_loaded = 0;
  int gen_remaining = 0;

  word_t drv_word;
  int    gap_left;
  int    burst_left;
  int    idle_cycles = 0;
  int    errors = 0;

  kth_remaining_removal u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .kind_i             (kind_i),
    .value_i            (value_i),
    .rank_i             (rank_i),
    .done_o             (done_o),
    .removed_value_o    (removed_value_o),
    .removed_position_o (removed_position_o),
    .status_o           (status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void predict_outcome(logic k, logic [63:0] v, logic [RANK_W-1:0] r);
    outcome_t want;
    int       idx;
    want.value = '0;
    want.position = '0;
    want.status = ST_OK;
    if (k == KIND_LOAD) begin
      if (shadow_loaded >= CAPACITY) begin
        want.status = ST_FULL;
      end else begin
        shadow_val[shadow_loaded] = v;
        present_pos.push_back(shadow_loaded);
        shadow_loaded++;
      end
    end else if (r == 0 || int'(r) > present_pos.size()) begin
      want.status = ST_BAD_RANK;
    end else begin
      idx = int'(r) - 1;
      want.position = present_pos[idx];
      want.value = shadow_val[present_pos[idx]];
      present_pos.delete(idx);
    end
    outcome_q.push_back(want);
  endfunction

  function automatic void queue_word(kind_e k, logic [63:0] v, logic [RANK_W-1:0] r);
    word_t w;
    w.kind = k;
    w.value = v;
    w.rank = r;
    pending_words.push_back(w);
    if (k == KIND_LOAD && gen_loaded < CAPACITY) begin
      gen_loaded++;
      gen_remaining++;
    end else if (k == KIND_REMOVE && r != 0 && int'(r) <= gen_remaining) begin
      gen_remaining--;
    end
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return 64'h0;
      3: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [RANK_W-1:0] pick_bad_rank();
    if ($urandom_range(0, 3) == 0) return '0;
    return RANK_W'($urandom_range(2 ** RANK_W - 1, gen_remaining + 1));
  endfunction

  function automatic logic [RANK_W-1:0] pick_good_rank();
    case ($urandom_range(0, 7))
      0: return RANK_W'(1);
      1: return RANK_W'(gen_remaining);
      default: return RANK_W'($urandom_range(1, gen_remaining));
    endcase
  endfunction

  // sender: bursts of words separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      kind_i <= KIND_LOAD;
      value_i <= '0;
      rank_i <= '0;
      gap_left = 0;
      burst_left = 1;
    end else if (!start_i || !busy_o) begin
      if (gap_left > 0 || pending_words.size() == 0) begin
        start_i <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        drv_word = pending_words.pop_front();
        start_i <= 1'b1;
        kind_i <= drv_word.kind;
        value_i <= drv_word.value;
        rank_i <= drv_word.rank;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
        end
      end
    end
  end

  // result check, prediction on accept, and stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (outcome_q.size() == 0) begin
          $error("result word with nothing pending: value %0d position %0d status %0d",
                 removed_value_o, removed_position_o, status_o);
          errors++;
        end else begin
          if (removed_value_o !== outcome_q[0].value) begin
            $error("removed_value: expected %0d, got %0d", outcome_q[0].value,
                   removed_value_o);
            errors++;
          end
          if (removed_position_o !== outcome_q[0].position) begin
            $error("removed_position: expected %0d, got %0d", outcome_q[0].position,
                   removed_position_o);
            errors++;
          end
          if (status_o !== outcome_q[0].status) begin
            $error("status: expected %0d, got %0d", outcome_q[0].status, status_o);
            errors++;
          end
          void'(outcome_q.pop_front());
        end
      end
      if (start_i === 1'b1 && busy_o === 1'b0) begin
        predict_outcome(kind_i, value_i, rank_i);
      end
      if (done_o === 1'b1 || (start_i === 1'b1 && busy_o === 1'b0)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int pick;
    // bad ranks on an empty store
    queue_word(KIND_REMOVE, '0, RANK_W'(1));
    queue_word(KIND_REMOVE, '0, '0);
    queue_word(KIND_REMOVE, '0, RANK_W'(CAPACITY));
    queue_word(KIND_REMOVE, '1, '1);
    // value extremes and bit patterns (rank is ignored on load), then bad ranks
    queue_word(KIND_LOAD, 64'h8000_0000_0000_0000, '1);
    queue_word(KIND_LOAD, 64'h7FFF_FFFF_FFFF_FFFF, '0);
    queue_word(KIND_LOAD, 64'h0, RANK_W'(1));
    queue_word(KIND_LOAD, '1, RANK_W'(2));
    queue_word(KIND_LOAD, 64'h5555_5555_5555_5555, 13'h0AAA);
    queue_word(KIND_LOAD, 64'hAAAA_AAAA_AAAA_AAAA, 13'h1555);
    queue_word(KIND_REMOVE, 64'h1234_5678_9ABC_DEF0, '0);
    queue_word(KIND_REMOVE, '0, RANK_W'(gen_remaining + 1));
    queue_word(KIND_REMOVE, '0, '1);
    queue_word(KIND_REMOVE, '0, RANK_W'(CAPACITY));

    // loads, removals at random ranks and bad ranks, mixed
    repeat (RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (gen_remaining == 0 || pick < 50) begin
        queue_word(KIND_LOAD, pick_value(), RANK_W'($urandom));
      end else if (pick < 60) begin
        queue_word(KIND_REMOVE, pick_value(), pick_bad_rank());
      end else begin
        queue_word(KIND_REMOVE, pick_value(), pick_good_rank());
      end
    end

    // rank limits of what is left
    queue_word(KIND_REMOVE, '0, RANK_W'(gen_remaining + 1));
    if (gen_remaining > 0) queue_word(KIND_REMOVE, '1, RANK_W'(gen_remaining));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pending_words.size() != 0 || start_i || outcome_q.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
